FILE: rtl/core/glcdw_pkg.sv
// Package for the graphic panel text writer: queue entry type, operation codes,
// panel geometry constants and the 5x7 font ROM.
// Depends on nothing; used by every module of the block.
package glcdw_pkg;

	// Input function codes
	localparam logic [2:0] FN_PRINT    = 3'd0;
	localparam logic [2:0] FN_SETCUR   = 3'd1;
	localparam logic [2:0] FN_HALF     = 3'd2;
	localparam logic [2:0] FN_RAWCMD   = 3'd3;
	localparam logic [2:0] FN_RAWDATA  = 3'd4;

	// Panel geometry and command encoding
	localparam logic [7:0] PAGE_CMD_BASE   = 8'hB8;
	localparam logic [7:0] COL_LIMIT       = 8'd121;
	localparam logic [6:0] LEFT_LAST_COL   = 7'd60;
	localparam logic [6:0] RIGHT_FIRST_COL = 7'd61;
	localparam logic [6:0] SKIPPED_COL     = 7'd120;
	localparam logic [7:0] DATA_INV        = 8'hFF;

	// Character set
	localparam logic [7:0] FIRST_CODE  = 8'd32;
	localparam logic [7:0] GLYPH_COUNT = 8'd94;
	localparam logic [7:0] LAST_CODE   = FIRST_CODE + GLYPH_COUNT - 8'd1;
	localparam logic [2:0] LAST_GCOL   = 3'd5;  // sixth column, always blank
	localparam logic [2:0] GLYPH_COLS  = 3'd6;

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_PRINT,
		OP_SETCUR,
		OP_RAWCMD,
		OP_RAWDATA
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] arg;   // glyph index for print, byte for raw writes
		logic [6:0] col;   // wrapped cursor column for set cursor
		logic [1:0] page;  // wrapped cursor page for set cursor
		logic       half;  // raw target half
	} qentry_t;

	typedef enum logic [1:0] {
		BK_PAGE,
		BK_COL,
		BK_DATA
	} bk_state_t;

	// Five font columns of one glyph, first column in the top byte
	function automatic logic [39:0] glyph_row(input logic [6:0] g);
		logic [39:0] r;
		case (g)
			7'd0:  r = 40'h0000000000;
			7'd1:  r = 40'h00005F0000;
			7'd2:  r = 40'h0007000700;
			7'd3:  r = 40'h147F147F14;
			7'd4:  r = 40'h242A7F2A12;
			7'd5:  r = 40'h2313086462;
			7'd6:  r = 40'h3649552250;
			7'd7:  r = 40'h0005030000;
			7'd8:  r = 40'h001C224100;
			7'd9:  r = 40'h0041221C00;
			7'd10: r = 40'h082A1C2A08;
			7'd11: r = 40'h08083E0808;
			7'd12: r = 40'h0050300000;
			7'd13: r = 40'h0808080808;
			7'd14: r = 40'h0060600000;
			7'd15: r = 40'h2010080402;
			7'd16: r = 40'h3E5149453E;
			7'd17: r = 40'h00427F4000;
			7'd18: r = 40'h4261514946;
			7'd19: r = 40'h2141454B31;
			7'd20: r = 40'h1814127F10;
			7'd21: r = 40'h2745454539;
			7'd22: r = 40'h3C4A494930;
			7'd23: r = 40'h0171090503;
			7'd24: r = 40'h3649494936;
			7'd25: r = 40'h064949291E;
			7'd26: r = 40'h0036360000;
			7'd27: r = 40'h0056360000;
			7'd28: r = 40'h0008142241;
			7'd29: r = 40'h1414141414;
			7'd30: r = 40'h4122140800;
			7'd31: r = 40'h0201510906;
			7'd32: r = 40'h324979413E;
			7'd33: r = 40'h7E1111117E;
			7'd34: r = 40'h7F49494936;
			7'd35: r = 40'h3E41414122;
			7'd36: r = 40'h7F4141221C;
			7'd37: r = 40'h7F49494941;
			7'd38: r = 40'h7F09090101;
			7'd39: r = 40'h3E41415132;
			7'd40: r = 40'h7F0808087F;
			7'd41: r = 40'h00417F4100;
			7'd42: r = 40'h2040413F01;
			7'd43: r = 40'h7F08142241;
			7'd44: r = 40'h7F40404040;
			7'd45: r = 40'h7F0204027F;
			7'd46: r = 40'h7F0408107F;
			7'd47: r = 40'h3E4141413E;
			7'd48: r = 40'h7F09090906;
			7'd49: r = 40'h3E4151215E;
			7'd50: r = 40'h7F09192946;
			7'd51: r = 40'h4649494931;
			7'd52: r = 40'h01017F0101;
			7'd53: r = 40'h3F4040403F;
			7'd54: r = 40'h1F2040201F;
			7'd55: r = 40'h7F2018207F;
			7'd56: r = 40'h6314081463;
			7'd57: r = 40'h0304780403;
			7'd58: r = 40'h6151494543;
			7'd59: r = 40'h00007F4141;
			7'd60: r = 40'h0204081020;
			7'd61: r = 40'h41417F0000;
			7'd62: r = 40'h0402010204;
			7'd63: r = 40'h4040404040;
			7'd64: r = 40'h0001020400;
			7'd65: r = 40'h2054545478;
			7'd66: r = 40'h7F48444438;
			7'd67: r = 40'h3844444420;
			7'd68: r = 40'h384444487F;
			7'd69: r = 40'h3854545418;
			7'd70: r = 40'h087E090102;
			7'd71: r = 40'h081454543C;
			7'd72: r = 40'h7F08040478;
			7'd73: r = 40'h00447D4000;
			7'd74: r = 40'h2040443D00;
			7'd75: r = 40'h007F102844;
			7'd76: r = 40'h00417F4000;
			7'd77: r = 40'h7C04180478;
			7'd78: r = 40'h7C08040478;
			7'd79: r = 40'h3844444438;
			7'd80: r = 40'h7C14141408;
			7'd81: r = 40'h081414187C;
			7'd82: r = 40'h7C08040408;
			7'd83: r = 40'h4854545420;
			7'd84: r = 40'h043F444020;
			7'd85: r = 40'h3C4040207C;
			7'd86: r = 40'h1C2040201C;
			7'd87: r = 40'h3C4030403C;
			7'd88: r = 40'h4428102844;
			7'd89: r = 40'h0C5050503C;
			7'd90: r = 40'h4464544C44;
			7'd91: r = 40'h0008364100;
			7'd92: r = 40'h00007F0000;
			7'd93: r = 40'h0041360800;
			default: r = 40'h0000000000;
		endcase
		return r;
	endfunction

	// One column byte of a glyph; the sixth column is the blank spacer
	function automatic logic [7:0] glyph_col(input logic [6:0] g, input logic [2:0] c);
		logic [39:0] r;
		logic [7:0]  b;
		r = glyph_row(g);
		case (c)
			3'd0:    b = r[39:32];
			3'd1:    b = r[31:24];
			3'd2:    b = r[23:16];
			3'd3:    b = r[15:8];
			3'd4:    b = r[7:0];
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

FILE: rtl/core/glcdw_front.sv
// Front end of the panel text writer: accepts input transactions, classifies
// them, holds the raw target half and pushes work into the command queue.
// Depends on glcdw_pkg.
module glcdw_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         func,
	input  logic [7:0]         value,
	input  logic [7:0]         col,
	input  logic [1:0]         page,
	output logic               push,
	output glcdw_pkg::qentry_t push_entry,
	input  logic               q_ready
);
	import glcdw_pkg::*;

	logic raw_half_q;
	logic accept;
	logic keep;

	assign in_ready = q_ready;
	assign accept   = in_valid && in_ready;
	assign push     = accept && keep;

	// Classify the transaction and build its queue entry
	always_comb begin
		keep            = 1'b0;
		push_entry.op   = OP_PRINT;
		push_entry.arg  = value;
		push_entry.col  = '0;
		push_entry.page = '0;
		push_entry.half = raw_half_q;
		case (func)
			FN_PRINT: begin
				keep           = value inside {[FIRST_CODE:LAST_CODE]};
				push_entry.arg = value - FIRST_CODE;
			end
			FN_SETCUR: begin
				keep          = 1'b1;
				push_entry.op = OP_SETCUR;
				if (col >= COL_LIMIT) begin
					push_entry.col  = '0;
					push_entry.page = page + 2'd1;
				end else begin
					push_entry.col  = col[6:0];
					push_entry.page = page;
				end
			end
			FN_RAWCMD: begin
				keep          = 1'b1;
				push_entry.op = OP_RAWCMD;
			end
			FN_RAWDATA: begin
				keep          = 1'b1;
				push_entry.op = OP_RAWDATA;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	// Hold the raw target half chosen by select-half transactions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_half_q <= 1'b0;
		end else if (accept && func == FN_HALF) begin
			raw_half_q <= value[0];
		end
	end

endmodule

FILE: rtl/core/glcdw_queue.sv
// Short command queue between the front end and the write sequencer.
// Depends on glcdw_pkg for the entry type and depth.
module glcdw_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  glcdw_pkg::qentry_t push_entry,
	output logic               q_ready,
	output logic               head_valid,
	output glcdw_pkg::qentry_t head,
	input  logic               pop
);
	import glcdw_pkg::*;

	qentry_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign q_ready    = count_q != QCNT_W'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/glcdw_back.sv
// Write sequencer: turns the queue head into panel bus writes, one per cycle while
// out_ready does not stall the output, tracks the cursor and drives the registered
// output channel. Depends on glcdw_pkg for the font ROM, constants and types.
module glcdw_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               invert,
	input  logic               head_valid,
	input  glcdw_pkg::qentry_t head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               is_data,
	output logic [7:0]         bus_byte,
	output logic               target_half,
	output logic               last
);
	import glcdw_pkg::*;

	bk_state_t  state_q;
	bk_state_t  state_d;
	logic [2:0] gcol_q;
	logic       wrap_q;
	logic [6:0] col_q;
	logic [1:0] page_q;
	logic       out_valid_q;

	logic       is_setcur;
	logic       is_raw;
	logic       out_free;
	logic       advance;
	logic [6:0] cur_col;
	logic [1:0] cur_page;
	logic       cur_half;
	logic [6:0] nxt_col;
	logic       em_is_data;
	logic [7:0] em_byte;
	logic       em_half;
	logic       em_last;

	assign is_setcur = head.op == OP_SETCUR;
	assign is_raw    = head.op == OP_RAWCMD || head.op == OP_RAWDATA;
	assign out_free  = !out_valid_q || out_ready;
	assign advance   = head_valid && out_free;
	assign pop       = advance && em_last;
	assign out_valid = out_valid_q;

	// A set cursor places the new position on its first write
	assign cur_col  = (state_q == BK_PAGE && is_setcur) ? head.col : col_q;
	assign cur_page = (state_q == BK_PAGE && is_setcur) ? head.page : page_q;
	assign cur_half = cur_col > LEFT_LAST_COL;
	assign nxt_col  = col_q + 7'd1;

	// Write contents for the current step
	always_comb begin
		em_is_data = 1'b0;
		em_byte    = 8'h00;
		em_half    = cur_half;
		em_last    = 1'b0;
		case (state_q)
			BK_PAGE: begin
				if (is_raw) begin
					em_is_data = head.op == OP_RAWDATA;
					em_byte    = head.arg;
					em_half    = head.half;
					em_last    = 1'b1;
				end else begin
					em_byte = PAGE_CMD_BASE + {6'd0, cur_page};
				end
			end
			BK_COL: begin
				em_byte = {1'b0, cur_half ? cur_col - RIGHT_FIRST_COL : cur_col};
				em_last = is_setcur || (wrap_q && gcol_q == GLYPH_COLS);
			end
			BK_DATA: begin
				em_is_data = 1'b1;
				em_byte    = glyph_col(head.arg[6:0], gcol_q) ^ (invert ? DATA_INV : 8'h00);
				em_last    = gcol_q == LAST_GCOL && nxt_col != SKIPPED_COL;
			end
			default: begin
				em_byte = 8'h00;
			end
		endcase
	end

	// Next step of the sequence
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_PAGE: begin
				state_d = is_raw ? BK_PAGE : BK_COL;
			end
			BK_COL: begin
				state_d = (em_last || wrap_q) ? BK_PAGE : BK_DATA;
			end
			BK_DATA: begin
				state_d = BK_PAGE;
			end
			default: begin
				state_d = BK_PAGE;
			end
		endcase
	end

	// Advance sequencer and cursor on each write handed to the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_PAGE;
			gcol_q  <= '0;
			wrap_q  <= 1'b0;
			col_q   <= '0;
			page_q  <= '0;
		end else if (advance) begin
			state_q <= state_d;
			if (state_q == BK_PAGE && is_setcur) begin
				col_q  <= head.col;
				page_q <= head.page;
			end
			if (state_q == BK_COL) begin
				wrap_q <= 1'b0;
			end
			if (state_q == BK_DATA) begin
				gcol_q <= gcol_q + 3'd1;
				// skip the last column and wrap onto the next page
				if (nxt_col >= SKIPPED_COL) begin
					col_q  <= '0;
					page_q <= page_q + 2'd1;
					wrap_q <= nxt_col == SKIPPED_COL;
				end else begin
					col_q <= nxt_col;
				end
			end
			if (em_last) begin
				gcol_q <= '0;
				wrap_q <= 1'b0;
			end
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= head_valid;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			is_data     <= em_is_data;
			bus_byte    <= em_byte;
			target_half <= em_half;
			last        <= em_last;
		end
	end

endmodule

FILE: rtl/core/glcd_text_cursor_writer.sv
// Text writer for a two-controller 122x32 graphic panel: one panel bus write per
// cycle while out_ready does not stall it. An item is registered in the command
// queue and its writes in the output register. The write sequencer sets the pace;
// items without writes never enter the queue; it takes new items while not full.
// Reset: cursor at column 0 page 0, raw half left, invert off, queue empty.
// Depends on glcdw_pkg, glcdw_front, glcdw_queue and glcdw_back.
module glcd_text_cursor_writer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] func,
	input  logic [7:0] value,
	input  logic [7:0] col,
	input  logic [1:0] page,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       is_data,
	output logic [7:0] bus_byte,
	output logic       target_half,
	output logic       last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data
);
	import glcdw_pkg::*;

	logic    invert_q;
	logic    push;
	qentry_t push_entry;
	logic    q_ready;
	logic    head_valid;
	qentry_t head;
	logic    pop;

	assign cfg_ready = 1'b1;

	// Hold the invert register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			invert_q <= cfg_data;
		end
	end

	glcdw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.value      (value),
		.col        (col),
		.page       (page),
		.push       (push),
		.push_entry (push_entry),
		.q_ready    (q_ready)
	);

	glcdw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.q_ready    (q_ready),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	glcdw_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.invert      (invert_q),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.is_data     (is_data),
		.bus_byte    (bus_byte),
		.target_half (target_half),
		.last        (last)
	);

endmodule

FILE: bench/glcd_text_cursor_writer_tb.sv
// Testbench for glcd_text_cursor_writer: drives characters, cursor moves and raw
// writes, predicts every panel bus write and checks each one in order.
// Depends on glcdw_pkg and the glcd_text_cursor_writer RTL.
module glcd_text_cursor_writer_tb;
	import glcdw_pkg::*;

	localparam logic [2:0] FN_FIRST_UNUSED = 3'd5;
	localparam logic [2:0] FN_MAX          = 3'd7;
	localparam int         SETTLE_CYCLES   = 8;
	localparam int         HOLD_CYCLES     = 300;
	localparam int         CYCLE_LIMIT     = 300000;

	typedef struct packed {
		logic       is_data;
		logic [7:0] bus_byte;
		logic       half;
		logic       last;
	} bus_write_t;

	// Panel cursor tracker and queue of the bus writes still owed by the block
	class text_scoreboard;
		bus_write_t  writes_due[$];
		logic [39:0] font[94];
		logic [7:0]  cur_col;
		logic [1:0]  cur_page;
		logic        raw_half;
		logic        invert;
		int          errors;

		function new();
			font = '{
				40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
				40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
				40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
				40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
				40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
				40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
				40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
				40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
				40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
				40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
				40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
				40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
				40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
				40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
				40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
				40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040,
				40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
				40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h081454543C,
				40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h007F102844,
				40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
				40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
				40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
				40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
				40'h00007F0000, 40'h0041360800
			};
			cur_col  = '0;
			cur_page = '0;
			raw_half = 1'b0;
			invert   = 1'b0;
			errors   = 0;
		endfunction

		function void push_write(logic d, logic [7:0] b, logic h);
			bus_write_t w;
			w = '{is_data: d, bus_byte: b, half: h, last: 1'b0};
			writes_due.push_back(w);
		endfunction

		// Wrap past the last column, then send page and column commands
		function void place_cursor();
			logic right;
			if (cur_col >= COL_LIMIT) begin
				cur_page = cur_page + 2'd1;
				cur_col  = '0;
			end
			right = (cur_col > LEFT_LAST_COL);
			push_write(1'b0, PAGE_CMD_BASE + cur_page, right);
			push_write(1'b0, right ? cur_col - RIGHT_FIRST_COL : cur_col, right);
		endfunction

		// Work out the bus writes of one accepted transaction
		function void note_input(logic [2:0] f, logic [7:0] v, logic [7:0] c, logic [1:0] p);
			int         first;
			logic [6:0] g;
			logic [7:0] b;
			first = writes_due.size();
			case (f)
				FN_PRINT: begin
					if (v >= FIRST_CODE && v <= LAST_CODE) begin
						g = 7'(v - FIRST_CODE);
						for (int i = 0; i < GLYPH_COLS; i++) begin
							b = (i < LAST_GCOL) ? font[g][39 - 8 * i -: 8] : 8'h00;
							place_cursor();
							if (invert)
								b = b ^ DATA_INV;
							push_write(1'b1, b, cur_col > LEFT_LAST_COL);
							cur_col = cur_col + 8'd1;
							// skip the dead column and move to the next page
							if (cur_col == SKIPPED_COL) begin
								cur_col = COL_LIMIT;
								place_cursor();
							end
						end
					end
				end
				FN_SETCUR: begin
					cur_col  = c;
					cur_page = p;
					place_cursor();
				end
				FN_HALF:    raw_half = v[0];
				FN_RAWCMD:  push_write(1'b0, v, raw_half);
				FN_RAWDATA: push_write(1'b1, v, raw_half);
				default: ;
			endcase
			if (writes_due.size() > first)
				writes_due[writes_due.size() - 1].last = 1'b1;
		endfunction

		function void field_check(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			end
		endfunction

		// Compare one bus write against the oldest one owed
		function void check_result(logic d, logic [7:0] b, logic h, logic l);
			bus_write_t want;
			if (writes_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected bus write, expected none actual %0b/%h/%0b/%0b",
					$time, d, b, h, l);
				return;
			end
			want = writes_due.pop_front();
			field_check("is_data", want.is_data, d);
			field_check("bus_byte", want.bus_byte, b);
			field_check("target_half", want.half, h);
			field_check("last", want.last, l);
		endfunction

		function int pending();
			return writes_due.size();
		endfunction
	endclass

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       in_valid    = 1'b0;
	logic [2:0] func        = FN_PRINT;
	logic [7:0] value       = '0;
	logic [7:0] col         = '0;
	logic [1:0] page        = '0;
	logic       out_ready   = 1'b0;
	logic       cfg_valid   = 1'b0;
	logic       cfg_data    = 1'b0;
	logic       in_ready;
	logic       out_valid;
	logic       is_data;
	logic [7:0] bus_byte;
	logic       target_half;
	logic       last;
	logic       cfg_ready;

	int             snd_idle_pct = 13;
	int             rcv_idle_pct = 81;
	logic           hold_req     = 1'b0;
	int             cycle_count  = 0;
	text_scoreboard sb;

	glcd_text_cursor_writer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.value      (value),
		.col        (col),
		.page       (page),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.is_data    (is_data),
		.bus_byte   (bus_byte),
		.target_half(target_half),
		.last       (last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always #5 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Check every bus write transaction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(is_data, bus_byte, target_half, last);
	end

	// Drive out_ready: random stalls, or a long hold-off on request
	initial begin : rx_ready
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	// Offer one transaction, idling first at random; valid stays high on return
	task automatic send_item(input logic [2:0] f, input logic [7:0] v,
		input logic [7:0] c, input logic [1:0] p);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func     <= f;
		value    <= v;
		col      <= c;
		page     <= p;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_input(f, v, c, p);
	endtask

	// Drop valid and wait until every owed write has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_invert(input logic v);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.invert = v;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Random mix, mostly printable text, with cursor moves near the line end or anywhere
	task automatic send_random(input int count);
		int         done_n;
		int         pick;
		logic [2:0] f;
		logic [7:0] v;
		logic [7:0] c;
		logic [1:0] p;
		done_n = 0;
		while (done_n < count) begin
			pick = $urandom_range(99);
			v    = 8'($urandom);
			c    = 8'($urandom);
			p    = 2'($urandom);
			if (pick < 55) begin
				f = FN_PRINT;
				if ($urandom_range(19) != 0)
					v = 8'($urandom_range(LAST_CODE, FIRST_CODE));
			end else if (pick < 70) begin
				f = FN_SETCUR;
				case ($urandom_range(2))
					0: c = 8'($urandom_range(COL_LIMIT, 100));
					1: c = 8'($urandom_range(70, 0));
					default: ;
				endcase
			end else if (pick < 78) begin
				f = FN_HALF;
			end else if (pick < 86) begin
				f = FN_RAWCMD;
			end else if (pick < 94) begin
				f = FN_RAWDATA;
			end else begin
				f = 3'($urandom_range(FN_MAX, FN_FIRST_UNUSED));
			end
			send_item(f, v, c, p);
			if (f <= FN_RAWDATA && !(f == FN_PRINT && (v < FIRST_CODE || v > LAST_CODE)))
				done_n++;
		end
	endtask

	initial begin
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_invert(1'b0);

		// first and last printable codes from the home position
		send_item(FN_PRINT, FIRST_CODE, 8'd0, 2'd0);
		send_item(FN_PRINT, LAST_CODE, 8'd0, 2'd0);
		// codes outside the font emit nothing
		send_item(FN_PRINT, FIRST_CODE - 8'd1, 8'd0, 2'd0);
		send_item(FN_PRINT, LAST_CODE + 8'd1, 8'd0, 2'd0);
		send_item(FN_PRINT, 8'hFF, 8'd0, 2'd0);
		// cursor on both sides of the half boundary, and past the last column
		send_item(FN_SETCUR, 8'd0, LEFT_LAST_COL, 2'd1);
		send_item(FN_SETCUR, 8'd0, RIGHT_FIRST_COL, 2'd2);
		send_item(FN_SETCUR, 8'd0, COL_LIMIT, 2'd3);
		send_item(FN_SETCUR, 8'd0, 8'hFF, 2'd2);
		// glyph that crosses into the right half
		send_item(FN_SETCUR, 8'd0, 8'd57, 2'd1);
		send_item(FN_PRINT, "W", 8'd0, 2'd0);
		// glyphs that run into the skipped column and wrap the page
		send_item(FN_SETCUR, 8'd0, 8'd114, 2'd3);
		send_item(FN_PRINT, "A", 8'd0, 2'd0);
		send_item(FN_SETCUR, 8'd0, 8'd119, 2'd0);
		send_item(FN_PRINT, "g", 8'd0, 2'd0);
		// raw writes follow the selected half; only bit 0 picks it
		send_item(FN_HALF, 8'h01, 8'd0, 2'd0);
		send_item(FN_RAWCMD, 8'hFF, 8'd0, 2'd0);
		send_item(FN_RAWDATA, 8'h00, 8'd0, 2'd0);
		send_item(FN_HALF, 8'hFE, 8'd0, 2'd0);
		send_item(FN_RAWDATA, 8'hA5, 8'd0, 2'd0);
		send_item(FN_RAWCMD, 8'h00, 8'd0, 2'd0);
		// unused function codes are dropped
		for (int f = FN_FIRST_UNUSED; f <= FN_MAX; f++)
			send_item(3'(f), 8'hFF, 8'hFF, 2'd3);

		// inverted glyph data; raw data stays as sent
		write_invert(1'b1);
		send_item(FN_PRINT, "Z", 8'd0, 2'd0);
		send_item(FN_RAWDATA, 8'h3C, 8'd0, 2'd0);

		// slow receiver, with a long hold-off while the sender keeps going
		send_random(60);
		hold_req = 1'b1;
		send_random(30);
		wait_drained();
		send_random(25);

		// slow sender
		write_invert(1'b0);
		snd_idle_pct = 81;
		rcv_idle_pct = 13;
		send_random(100);

		// no idling on either side
		write_invert(1'b1);
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		send_random(100);

		wait_drained();
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
